/* rtl/ctqle_pkg.sv */
// ----------------------------------------------------------------------------
// ctqle_pkg
// Shared types and character codes for the console transmit queue.
// ----------------------------------------------------------------------------
package ctqle_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_SP = 8'h20;

  // expansion class of one character
  typedef enum logic [1:0] {
    CLS_PLAIN = 2'd0,
    CLS_NL    = 2'd1,
    CLS_BS    = 2'd2
  } cls_t;

  // classified command handed from the front to the back
  typedef struct packed {
    logic       kind;
    logic       enq;
    cls_t       cls;
    logic [7:0] b0;
    logic       tx_empty;
  } cmd_t;

endpackage

/* rtl/console_tx_queue_with_line_expansion.sv */
// ----------------------------------------------------------------------------
// console_tx_queue_with_line_expansion
// Console transmit byte queue with newline and backspace expansion, echo of
// received characters and transmitter service.
// ----------------------------------------------------------------------------
//   channel   handshake        payload
//   in_       in_push/in_full  kind, char_in, rx_ready, rx_char, tx_empty
//   out_      out_pop/out_empty tx_valid, tx_byte, tx_irq_enable, status,
//                               fill_level
//
// an item passes through the back end in order: taking the command, writing
// each expanded byte to the single-port byte store, deciding the pop, a wait
// for the registered store read when a byte is popped, and loading the
// result. a two-entry command queue keeps taking transactions while the back
// end works or a result waits; the back end starts the next command only once
// the result register is free. synchronous reset, no clearing pass.
module console_tx_queue_with_line_expansion #(
  parameter int  QUEUE_DEPTH = 16,
  localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_kind,
  input  logic [7:0]    in_char_in,
  input  logic          in_rx_ready,
  input  logic [7:0]    in_rx_char,
  input  logic          in_tx_empty,
  input  logic          in_push,
  output logic          in_full,
  output logic          out_tx_valid,
  output logic [7:0]    out_tx_byte,
  output logic          out_tx_irq_enable,
  output logic          out_status,
  output logic [CW-1:0] out_fill_level,
  output logic          out_empty,
  input  logic          out_pop
);
  import ctqle_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  ctqle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_kind),
    .in_char_in  (in_char_in),
    .in_rx_ready (in_rx_ready),
    .in_rx_char  (in_rx_char),
    .in_tx_empty (in_tx_empty),
    .in_push     (in_push),
    .in_full     (in_full),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop)
  );

  ctqle_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          ($clog2(QUEUE_DEPTH)),
    .CW          (CW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cmd_valid         (cmd_valid),
    .cmd_pop           (cmd_pop),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte),
    .out_tx_irq_enable (out_tx_irq_enable),
    .out_status        (out_status),
    .out_fill_level    (out_fill_level),
    .out_empty         (out_empty),
    .out_pop           (out_pop)
  );

endmodule

/* rtl/ctqle_front.sv */
// ----------------------------------------------------------------------------
// ctqle_front
// Accepts input transactions, classifies the character and holds the
// resulting commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ctqle_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_kind,
  input  logic [7:0]      in_char_in,
  input  logic            in_rx_ready,
  input  logic [7:0]      in_rx_char,
  input  logic            in_tx_empty,
  input  logic            in_push,
  output logic            in_full,
  output ctqle_pkg::cmd_t cmd,
  output logic            cmd_valid,
  input  logic            cmd_pop
);
  import ctqle_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_sel_r, wr_sel_nxt;
  logic       rd_sel_r, rd_sel_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] ch;
  cmd_t       cls_cmd;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    ch               = in_kind ? in_rx_char : in_char_in;
    cls_cmd.kind     = in_kind;
    cls_cmd.enq      = !in_kind || in_rx_ready;
    cls_cmd.tx_empty = in_tx_empty;
    priority if (ch == CH_CR || ch == CH_LF) begin
      cls_cmd.cls = CLS_NL;
      cls_cmd.b0  = CH_LF;
    end else if (ch == CH_BS) begin
      cls_cmd.cls = CLS_BS;
      cls_cmd.b0  = CH_BS;
    end else begin
      cls_cmd.cls = CLS_PLAIN;
      cls_cmd.b0  = ch;
    end
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rd_sel_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_sel_nxt = do_push ? !wr_sel_r : wr_sel_r;
    rd_sel_nxt = do_pop ? !rd_sel_r : rd_sel_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_sel_r] <= cls_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_sel_r <= wr_sel_nxt;
      rd_sel_r <= rd_sel_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("command queue count out of range");

  a_sel_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_sel_r == rd_sel_r))
    else $error("command queue pointers disagree with count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("back end took a command from an empty queue");

endmodule

/* rtl/ctqle_back.sv */
// ----------------------------------------------------------------------------
// ctqle_back
// Carries out commands: writes the expansion into the byte queue one byte
// a cycle, then services the transmitter and registers the result.
// ----------------------------------------------------------------------------
module ctqle_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int AW          = $clog2(QUEUE_DEPTH),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ctqle_pkg::cmd_t cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  output logic            out_tx_valid,
  output logic [7:0]      out_tx_byte,
  output logic            out_tx_irq_enable,
  output logic            out_status,
  output logic [CW-1:0]   out_fill_level,
  output logic            out_empty,
  input  logic            out_pop
);
  import ctqle_pkg::*;

  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_POP   = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          en_r, en_nxt;
  logic          status_r, status_nxt;
  logic          popd_r, popd_nxt;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [QUEUE_DEPTH];

  logic          res_valid_r, res_valid_nxt;
  logic          res_tx_valid_r, res_tx_valid_nxt;
  logic [7:0]    res_byte_r, res_byte_nxt;
  logic          res_irq_r, res_irq_nxt;
  logic          res_status_r, res_status_nxt;
  logic [CW-1:0] res_fill_r, res_fill_nxt;

  logic          wr_en;
  logic          rd_en;
  logic [7:0]    wr_byte;
  logic [1:0]    len_new;
  logic [1:0]    len_cur;
  logic          fits;

  function automatic logic [1:0] exp_len(cls_t c);
    logic [1:0] n;
    unique case (c)
      CLS_PLAIN: n = 2'd1;
      CLS_NL:    n = 2'd2;
      CLS_BS:    n = 2'd3;
      default:   n = 2'd1;
    endcase
    return n;
  endfunction

  assign len_new = exp_len(cmd.cls);
  assign len_cur = exp_len(cur_r.cls);
  assign fits    = ({1'b0, fill_r} + {{(CW - 1){1'b0}}, len_new}) <= DEPTH_W;

  always_comb begin
    unique case (idx_r)
      2'd0:    wr_byte = cur_r.b0;
      2'd1:    wr_byte = (cur_r.cls == CLS_BS) ? CH_SP : CH_CR;
      default: wr_byte = CH_BS;
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    cur_nxt          = cur_r;
    idx_nxt          = idx_r;
    wr_ptr_nxt       = wr_ptr_r;
    rd_ptr_nxt       = rd_ptr_r;
    fill_nxt         = fill_r;
    en_nxt           = en_r;
    status_nxt       = status_r;
    popd_nxt         = popd_r;
    cmd_pop          = 1'b0;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    res_valid_nxt    = res_valid_r && !out_pop;
    res_tx_valid_nxt = res_tx_valid_r;
    res_byte_nxt     = res_byte_r;
    res_irq_nxt      = res_irq_r;
    res_status_nxt   = res_status_r;
    res_fill_nxt     = res_fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !res_valid_r) begin
          cmd_pop    = 1'b1;
          cur_nxt    = cmd;
          idx_nxt    = 2'd0;
          popd_nxt   = 1'b0;
          status_nxt = cmd.enq && !fits;
          state_nxt  = (cmd.enq && fits) ? S_WRITE : S_POP;
        end
      end
      S_WRITE: begin
        wr_en      = 1'b1;
        wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
        fill_nxt   = fill_r + CW'(1);
        idx_nxt    = idx_r + 2'd1;
        if (idx_r == len_cur - 2'd1) begin
          en_nxt    = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (cur_r.kind && fill_r != '0 && cur_r.tx_empty) begin
          rd_en      = 1'b1;
          rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
          fill_nxt   = fill_r - CW'(1);
          popd_nxt   = 1'b1;
          if (fill_r == CW'(1)) begin
            en_nxt = 1'b0;
          end
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid_nxt    = 1'b1;
        res_tx_valid_nxt = popd_r;
        res_byte_nxt     = popd_r ? rd_data_r : 8'd0;
        res_irq_nxt      = en_r;
        res_status_nxt   = status_r;
        res_fill_nxt     = fill_r;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // byte store, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    cur_r          <= cur_nxt;
    idx_r          <= idx_nxt;
    status_r       <= status_nxt;
    popd_r         <= popd_nxt;
    res_tx_valid_r <= res_tx_valid_nxt;
    res_byte_r     <= res_byte_nxt;
    res_irq_r      <= res_irq_nxt;
    res_status_r   <= res_status_nxt;
    res_fill_r     <= res_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      en_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      en_r        <= en_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign out_empty         = !res_valid_r;
  assign out_tx_valid      = res_tx_valid_r;
  assign out_tx_byte       = res_byte_r;
  assign out_tx_irq_enable = res_irq_r;
  assign out_status        = res_status_r;
  assign out_fill_level    = res_fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_r} <= DEPTH_W)
    else $error("byte queue fill above depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, fill_r} < DEPTH_W))
    else $error("byte written into a full queue");

  a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (fill_r != '0))
    else $error("byte read from an empty queue");

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !res_valid_r)
    else $error("result register overwritten before it was taken");

endmodule
